@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_pkg
// Shared widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package fau_pkg;

  localparam int IN_WIDTH_DEF = 16;
  localparam int ACT_W        = 3;
  localparam int NUM_W        = 33;
  localparam int DEN_W        = 32;
  localparam int ORD_W        = 2;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

  localparam logic [ORD_W-1:0] ORD_EQ = 2'd0;
  localparam logic [ORD_W-1:0] ORD_GT = 2'd1;
  localparam logic [ORD_W-1:0] ORD_LT = 2'd2;

  // Width of cross sums: one bit over a product, capped at 64
  function automatic int sum_w(input int w);
    int s;
    s = 2 * w + 1;
    return (s > 64) ? 64 : s;
  endfunction

  typedef struct packed {
    logic load;
    logic mult;
    logic prep;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } fau_cmd_t;

  typedef struct packed {
    logic direct;
    logic gcd_done;
  } fau_sts_t;

endpackage

@@ hw/rtl/fau_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_ctrl
// Sequencer: operand load, multiply, prepare, gcd loop, division, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fau_ctrl import fau_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  fau_sts_t sts,
  output fau_cmd_t cmd
);

  localparam int SW = sum_w(IN_WIDTH);
  localparam int CW = $clog2(SW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.direct ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CW'(SW - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_accept_to_mult, in_valid && !in_stall, state == S_MULT, "accepted item did not start")
  `ASSERT_IMPL(a_valid_from_done, $rose(out_valid), $past(state) == S_DONE, "result shown outside done")
  `ASSERT_IMPL(a_cnt_range, state == S_DIV, cnt <= CW'(SW - 1), "division counter overran")

endmodule

@@ hw/rtl/fau_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fau_dp
// Operand registers, cross products, binary gcd and two restoring dividers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fau_dp import fau_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fau_cmd_t                   cmd,
  output fau_sts_t                   sts,
  input  logic [ACT_W-1:0]           action,
  input  logic signed [IN_WIDTH-1:0] a_num,
  input  logic signed [IN_WIDTH-1:0] a_den,
  input  logic signed [IN_WIDTH-1:0] b_num,
  input  logic signed [IN_WIDTH-1:0] b_den,
  output logic signed [NUM_W-1:0]    res_num,
  output logic signed [DEN_W-1:0]    res_den,
  output logic [ORD_W-1:0]           order,
  output logic                       fault
);

  localparam int W  = IN_WIDTH;
  localparam int PW = 2 * IN_WIDTH;
  localparam int SW = sum_w(IN_WIDTH);

  // operands
  logic [ACT_W-1:0]    act;
  logic signed [W-1:0] an, ad, bn, bd;

  // products
  logic signed [PW-1:0] pa, pb, pc;
  logic signed [W-1:0]  ma, mc;

  // prepare stage
  logic signed [SW-1:0] pa_x, pb_x, pc_x, sum_v, diff_v, num_v;
  logic [SW-1:0]        mag_n, mag_d;
  logic                 fault_v, cmp_neg;
  logic [ORD_W-1:0]     order_v;

  // gcd and division state
  logic [SW-1:0] gx, gy, mn, md, dv, qn, qd, rn, rd;
  logic [SW:0]   tn, td, gsum;
  logic          sn, sd, direct_r, fault_r;
  logic [ORD_W-1:0]     order_r;
  logic signed [SW-1:0] sq_n, sq_d;

  assign ma = (act == ACT_MUL) ? bn : bd;
  assign mc = (act == ACT_DIV) ? bn : bd;

  assign pa_x   = SW'(pa);
  assign pb_x   = SW'(pb);
  assign pc_x   = SW'(pc);
  assign sum_v  = pa_x + pb_x;
  assign diff_v = pa_x - pb_x;

  always_comb begin
    case (act)
      ACT_ADD: num_v = sum_v;
      ACT_SUB: num_v = diff_v;
      default: num_v = pa_x;
    endcase
  end

  assign mag_n = num_v[SW-1] ? SW'(-num_v) : SW'(num_v);
  assign mag_d = pc_x[SW-1]  ? SW'(-pc_x)  : SW'(pc_x);

  assign fault_v = (act > ACT_CMP) || (ad == '0) || (bd == '0) ||
                   ((act == ACT_DIV) && (bn == '0));
  assign cmp_neg = diff_v[SW-1] ^ (ad[W-1] ^ bd[W-1]);

  always_comb begin
    if (fault_v || act != ACT_CMP) begin
      order_v = ORD_EQ;
    end else if (diff_v == '0) begin
      order_v = ORD_EQ;
    end else begin
      order_v = cmp_neg ? ORD_LT : ORD_GT;
    end
  end

  assign sts.direct   = fault_v || (act == ACT_CMP);
  assign sts.gcd_done = (gx == '0) || (gy == '0);
  assign gsum         = {1'b0, gx} + {1'b0, gy};

  // shift in the next dividend bit
  assign tn = {rn, qn[SW-1]};
  assign td = {rd, qd[SW-1]};

  assign sq_n = sn ? -$signed(qn) : $signed(qn);
  assign sq_d = sd ? -$signed(qd) : $signed(qd);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      an  <= a_num;
      ad  <= a_den;
      bn  <= b_num;
      bd  <= b_den;
    end

    if (cmd.mult) begin
      pa <= PW'(an) * PW'(ma);
      pb <= PW'(bn) * PW'(ad);
      pc <= PW'(ad) * PW'(mc);
    end

    if (cmd.prep) begin
      gx       <= mag_n;
      gy       <= mag_d;
      mn       <= mag_n;
      md       <= mag_d;
      sn       <= num_v[SW-1];
      sd       <= pc_x[SW-1];
      direct_r <= fault_v || (act == ACT_CMP);
      fault_r  <= fault_v;
      order_r  <= order_v;
    end

    if (cmd.gcd_step) begin
      if (!gx[0] && !gy[0]) begin
        // common factor of two: drop it from the magnitudes as well
        gx <= gx >> 1;
        gy <= gy >> 1;
        mn <= mn >> 1;
        md <= md >> 1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end

    if (cmd.div_start) begin
      dv <= gx | gy;
      qn <= mn;
      qd <= md;
      rn <= '0;
      rd <= '0;
    end

    if (cmd.div_step) begin
      if (tn >= {1'b0, dv}) begin
        rn <= SW'(tn - {1'b0, dv});
        qn <= {qn[SW-2:0], 1'b1};
      end else begin
        rn <= tn[SW-1:0];
        qn <= {qn[SW-2:0], 1'b0};
      end
      if (td >= {1'b0, dv}) begin
        rd <= SW'(td - {1'b0, dv});
        qd <= {qd[SW-2:0], 1'b1};
      end else begin
        rd <= td[SW-1:0];
        qd <= {qd[SW-2:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      if (direct_r) begin
        res_num <= '0;
        res_den <= '0;
      end else begin
        res_num <= NUM_W'(sq_n);
        res_den <= DEN_W'(sq_d);
      end
      order <= order_r;
      fault <= fault_r;
    end
  end

  `ASSERT_IMPL(a_divisor_nonzero, cmd.div_start, (gx | gy) != '0, "zero gcd at division start")
  `ASSERT_NEXT(a_gcd_shrinks, cmd.gcd_step, gsum < $past(gsum), "gcd step made no progress")
  `ASSERT_IMPL(a_fault_clean, cmd.out_load && fault_r, order_r == ORD_EQ && direct_r, "fault result not clean")

endmodule

@@ hw/rtl/fraction_alu_reduce_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_alu_reduce_top
// Signed fraction add, subtract, multiply, divide and compare with gcd
// reduction of the result.
// ----------------------------------------------------------------------------
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   input   | in_valid, in_stall | action, a_num, a_den, b_num, b_den
//   output  | out_valid,out_stall| res_num, res_den, order, fault
//
// One item at a time. Compare, fault and unknown actions skip the gcd loop
// and the division. Arithmetic runs the binary gcd loop and then a division
// that yields SW quotient bits, SW = 2*IN_WIDTH+1 (at most 64).
// A finished result waits in the output register while the next item loads.
// rst is synchronous and clears the sequencer and out_valid only.
// ----------------------------------------------------------------------------
module fraction_alu_reduce_top import fau_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACT_W-1:0]           action,
  input  logic signed [IN_WIDTH-1:0] a_num,
  input  logic signed [IN_WIDTH-1:0] a_den,
  input  logic signed [IN_WIDTH-1:0] b_num,
  input  logic signed [IN_WIDTH-1:0] b_den,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [NUM_W-1:0]    res_num,
  output logic signed [DEN_W-1:0]    res_den,
  output logic [ORD_W-1:0]           order,
  output logic                       fault
);

  fau_cmd_t cmd;
  fau_sts_t sts;

  fau_ctrl #(
    .IN_WIDTH (IN_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fau_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .action  (action),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .res_num (res_num),
    .res_den (res_den),
    .order   (order),
    .fault   (fault)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fraction_alu_reduce_top. A directed table covers
// faults, unknown actions, zero numerators, extreme operands and every
// compare outcome. Random operations follow. The sender works in bursts and
// the receiver stalls on its own pattern. Each result is compared field by
// field with a typed-in value or a behavioral predictor of the reduced fraction.
// ----------------------------------------------------------------------------
module testbench;
  import fau_pkg::*;

  localparam int IN_W       = IN_WIDTH_DEF;
  localparam int RAND_N     = 800;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_N     = 200;

  localparam logic [ACT_W-1:0] ACT_UNK5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNK6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNK7 = 3'd7;

  localparam logic signed [IN_W-1:0] MAX_V = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] MIN_V = {1'b1, {(IN_W-1){1'b0}}};

  typedef struct packed {
    logic [ACT_W-1:0]       act;
    logic signed [IN_W-1:0] a_num;
    logic signed [IN_W-1:0] a_den;
    logic signed [IN_W-1:0] b_num;
    logic signed [IN_W-1:0] b_den;
  } frac_op_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic [ORD_W-1:0]        ord;
    logic                    flt;
  } frac_res_t;

  typedef struct packed {
    frac_op_t  op;
    logic      known;
    frac_res_t want;
  } dir_row_t;

  localparam frac_res_t NO_RES    = '0;
  localparam frac_res_t FAULT_RES = '{num: '0, den: '0, ord: ORD_EQ, flt: 1'b1};
  localparam int DIR_N = 25;

  // known = 1: expected result is typed in; otherwise the predictor supplies it
  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{'{ACT_ADD, 16'sd0, 16'sd1, 16'sd0, 16'sd1}, 1'b1,
      '{33'sd0, 32'sd1, ORD_EQ, 1'b0}},
    '{'{ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1}, 1'b1, FAULT_RES},
    '{'{ACT_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1'b1, FAULT_RES},
    '{'{ACT_MUL, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, FAULT_RES},
    '{'{ACT_DIV, 16'sd1, 16'sd1, 16'sd0, 16'sd1}, 1'b1, FAULT_RES},
    '{'{ACT_CMP, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1'b1, FAULT_RES},
    '{'{ACT_UNK5, 16'sd3, 16'sd4, 16'sd5, 16'sd6}, 1'b1, FAULT_RES},
    '{'{ACT_UNK6, MAX_V, MIN_V, MAX_V, MIN_V}, 1'b1, FAULT_RES},
    '{'{ACT_UNK7, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1, FAULT_RES},
    '{'{ACT_MUL, MAX_V, 16'sd1, MAX_V, 16'sd1}, 1'b0, NO_RES},
    '{'{ACT_ADD, MIN_V, 16'sd1, MIN_V, 16'sd1}, 1'b0, NO_RES},
    '{'{ACT_MUL, MIN_V, MIN_V, MIN_V, MIN_V}, 1'b0, NO_RES},
    '{'{ACT_ADD, MIN_V, MIN_V, MIN_V, MIN_V}, 1'b0, NO_RES},
    '{'{ACT_SUB, MAX_V, MIN_V, MIN_V, MAX_V}, 1'b0, NO_RES},
    '{'{ACT_DIV, MIN_V, 16'sd1, 16'sd1, MIN_V}, 1'b0, NO_RES},
    '{'{ACT_DIV, 16'sd0, 16'sd5, 16'sd3, 16'sd7}, 1'b1,
      '{33'sd0, 32'sd1, ORD_EQ, 1'b0}},
    '{'{ACT_MUL, 16'sd0, -16'sd3, 16'sd4, 16'sd5}, 1'b1,
      '{33'sd0, -32'sd1, ORD_EQ, 1'b0}},
    '{'{ACT_SUB, 16'sd3, 16'sd7, 16'sd3, 16'sd7}, 1'b1,
      '{33'sd0, 32'sd1, ORD_EQ, 1'b0}},
    '{'{ACT_CMP, 16'sd1, 16'sd2, 16'sd1, 16'sd2}, 1'b1,
      '{33'sd0, 32'sd0, ORD_EQ, 1'b0}},
    '{'{ACT_CMP, 16'sd2, 16'sd3, 16'sd1, 16'sd3}, 1'b1,
      '{33'sd0, 32'sd0, ORD_GT, 1'b0}},
    '{'{ACT_CMP, 16'sd1, -16'sd3, 16'sd1, 16'sd3}, 1'b1,
      '{33'sd0, 32'sd0, ORD_LT, 1'b0}},
    '{'{ACT_CMP, MIN_V, -16'sd1, MAX_V, 16'sd1}, 1'b0, NO_RES},
    '{'{ACT_ADD, 16'sd6, 16'sd4, 16'sd3, -16'sd9}, 1'b0, NO_RES},
    '{'{ACT_DIV, 16'sd7, 16'sd3, -16'sd7, 16'sd3}, 1'b0, NO_RES},
    '{'{ACT_CMP, -16'sd1, -16'sd1, -16'sd1, 16'sd1}, 1'b0, NO_RES}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        action = ACT_ADD;
  logic signed [IN_W-1:0]  a_num = '0;
  logic signed [IN_W-1:0]  a_den = '0;
  logic signed [IN_W-1:0]  b_num = '0;
  logic signed [IN_W-1:0]  b_den = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [NUM_W-1:0] res_num;
  logic signed [DEN_W-1:0] res_den;
  logic [ORD_W-1:0]        order;
  logic                    fault;

  frac_res_t pending_fractions [$];
  int        mismatch_count = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  int        stall_left = 0;

  fraction_alu_reduce_top #(.IN_WIDTH(IN_W)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .order     (order),
    .fault     (fault)
  );

  always #4 clk = ~clk;

  function automatic longint gcd_of(input longint x, input longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(input frac_op_t op);
    longint an, ad, bn, bd, cross_a, cross_b, n, d, g;
    frac_res_t r;
    r  = '0;
    an = op.a_num;
    ad = op.a_den;
    bn = op.b_num;
    bd = op.b_den;
    if (op.act > ACT_CMP || ad == 0 || bd == 0 || (op.act == ACT_DIV && bn == 0)) begin
      r.flt = 1'b1;
      return r;
    end
    cross_a = an * bd;
    cross_b = bn * ad;
    d = ad * bd;
    case (op.act)
      ACT_ADD: n = cross_a + cross_b;
      ACT_SUB: n = cross_a - cross_b;
      ACT_MUL: n = an * bn;
      ACT_DIV: begin
        n = cross_a;
        d = ad * bn;
      end
      default: begin
        n = cross_a - cross_b;
        // the sign of the difference flips once per negative denominator
        if (n == 0)
          r.ord = ORD_EQ;
        else if ((n < 0) != ((ad < 0) != (bd < 0)))
          r.ord = ORD_LT;
        else
          r.ord = ORD_GT;
        return r;
      end
    endcase
    g = gcd_of((n < 0) ? -n : n, (d < 0) ? -d : d);
    if (g == 0)
      g = 1;
    r.num = NUM_W'(n / g);
    r.den = DEN_W'(d / g);
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_value();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3: return IN_W'($urandom);
      4, 5, 6, 7: return IN_W'(int'($urandom_range(0, 48)) - 24);
      8: begin
        case ($urandom_range(0, 4))
          0: return MIN_V;
          1: return MAX_V;
          2: return IN_W'(-1);
          3: return IN_W'(1);
          default: return '0;
        endcase
      end
      // shared powers of two give deep reductions
      default: return IN_W'((int'($urandom_range(0, 62)) - 31) <<< $urandom_range(0, 10));
    endcase
  endfunction

  function automatic frac_op_t random_op();
    frac_op_t op;
    op.act   = ($urandom_range(0, 99) < 4) ? ACT_W'($urandom_range(5, 7))
                                           : ACT_W'($urandom_range(0, 4));
    op.a_num = pick_value();
    op.a_den = pick_value();
    op.b_num = pick_value();
    op.b_den = pick_value();
    return op;
  endfunction

  // Drop valid for a random gap at the end of a burst
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3, 4, 5, 6, 7: gap = $urandom_range(1, 20);
        default: gap = $urandom_range(20, 150);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_op(input frac_op_t op, input logic known, input frac_res_t want);
    bit taken;
    in_valid <= 1'b1;
    action   <= op.act;
    a_num    <= op.a_num;
    a_den    <= op.a_den;
    b_num    <= op.b_num;
    b_den    <= op.b_den;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    pending_fractions.push_back(known ? want : reduce_fraction(op));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : stimulus
    int k;
    while (rst) @(posedge clk);
    for (k = 0; k < DIR_N; k++) begin
      pace_sender();
      send_op(dir_tab[k].op, dir_tab[k].known, dir_tab[k].want);
    end
    wait_drained();
    for (k = 0; k < RAND_N; k++) begin
      if (k == RAND_N / 2)
        wait_drained();
      pace_sender();
      send_op(random_op(), 1'b0, NO_RES);
    end
    wait_drained();
    repeat (TAIL_N) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: alternate stall and release runs, with occasional quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 300;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 6);
    end
  end

  // Sample mid-cycle: a transfer happens at the following rising edge
  always @(negedge clk) begin : result_check
    frac_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fractions.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result num=%0d den=%0d order=%0d fault=%0b",
                 $time, res_num, res_den, order, fault);
      end else begin
        want = pending_fractions.pop_front();
        if (res_num !== want.num) begin
          mismatch_count++;
          $display("%0t: res_num expected %0d, got %0d", $time, want.num, res_num);
        end
        if (res_den !== want.den) begin
          mismatch_count++;
          $display("%0t: res_den expected %0d, got %0d", $time, want.den, res_den);
        end
        if (order !== want.ord) begin
          mismatch_count++;
          $display("%0t: order expected %0d, got %0d", $time, want.ord, order);
        end
        if (fault !== want.flt) begin
          mismatch_count++;
          $display("%0t: fault expected %0b, got %0b", $time, want.flt, fault);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
